// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in rst.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cons must hold in the same cycle as ante
`define ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// cons must hold in the cycle after ante
`define ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/dslim_pkg.sv =====
// ----------------------------------------------------------------------------
// dslim_pkg
// Types, codes and constants of the dual ESC command slew limiter.
// ----------------------------------------------------------------------------
`default_nettype none

package dslim_pkg;

  localparam int PACKET_BYTES_DEF = 32;
  localparam int WIDTH_BITS_DEF   = 12;

  localparam int BYTE_W      = 8;
  localparam int OUT_W       = 12;
  localparam int STEP_W      = 10;
  localparam int CFG_DATA_W  = 12;
  localparam int CFG_INDEX_W = 8;
  localparam int OUT_TDATA_W = 32;

  localparam int RAMP_STEP_RST    = 50;
  localparam int WIDTH_MIN_RST    = 1000;
  localparam int WIDTH_MAX_RST    = 2000;
  localparam int WIDTH_CENTER_RST = 1500;
  localparam int TARGET_RST       = 1000;

  // packet byte positions
  localparam int HDR_LEN         = 4;
  localparam int POS_LEFT_FLAG   = 5;
  localparam int POS_LEFT_POWER  = 6;
  localparam int POS_UP_FLAG     = 7;
  localparam int POS_UP_POWER    = 8;
  localparam int POS_REVERSE     = 9;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_RAMP_STEP    = 8'd0,
    REG_WIDTH_MIN    = 8'd1,
    REG_WIDTH_MAX    = 8'd2,
    REG_WIDTH_CENTER = 8'd3
  } cfg_reg_e;

  typedef struct packed {
    logic              left_flag;
    logic [BYTE_W-1:0] left_power;
    logic              up_flag;
    logic [BYTE_W-1:0] up_power;
    logic              reverse_flag;
  } cmd_fields_t;

  typedef struct packed {
    logic              fire;
    logic [BYTE_W-1:0] data;
    logic              last;
  } pkt_byte_t;

  typedef struct packed {
    logic tick;
    logic arm;
  } ramp_ctl_t;

  // expected header "gas:"
  function automatic logic [BYTE_W-1:0] hdr_char(input logic [1:0] idx);
    logic [BYTE_W-1:0] c;
    case (idx)
      2'd0:    c = 8'h67;
      2'd1:    c = 8'h61;
      2'd2:    c = 8'h73;
      2'd3:    c = 8'h3A;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/dslim_parse.sv =====
// ----------------------------------------------------------------------------
// dslim_parse
// Counts packet bytes, checks the header and latches the command fields.
// ----------------------------------------------------------------------------
`default_nettype none

module dslim_parse
  import dslim_pkg::*;
#(
  parameter int PACKET_BYTES = PACKET_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire pkt_byte_t   pb,
  output      cmd_fields_t fields_next
);

  localparam int CW = $clog2(PACKET_BYTES + 1);

  logic [CW-1:0] byte_count, byte_count_next;
  logic          header_good, header_good_next;
  cmd_fields_t   fields;

  always_comb begin
    byte_count_next  = byte_count;
    header_good_next = header_good;
    fields_next      = fields;
    if (pb.fire) begin
      if (byte_count < CW'(PACKET_BYTES)) begin
        if (byte_count < CW'(HDR_LEN)) begin
          if (pb.data != hdr_char(byte_count[1:0])) begin
            header_good_next = 1'b0;
          end
        end else if (header_good) begin
          case (byte_count)
            CW'(POS_LEFT_FLAG):  fields_next.left_flag    = (pb.data != '0);
            CW'(POS_LEFT_POWER): fields_next.left_power   = pb.data;
            CW'(POS_UP_FLAG):    fields_next.up_flag      = (pb.data != '0);
            CW'(POS_UP_POWER):   fields_next.up_power     = pb.data;
            CW'(POS_REVERSE):    fields_next.reverse_flag = (pb.data != '0);
            default: ;
          endcase
        end
        byte_count_next = byte_count + CW'(1);
      end
      if (pb.last) begin
        byte_count_next  = '0;
        header_good_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count  <= '0;
      header_good <= 1'b1;
      fields      <= '0;
    end else begin
      byte_count  <= byte_count_next;
      header_good <= header_good_next;
      fields      <= fields_next;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/dslim_target.sv =====
// ----------------------------------------------------------------------------
// dslim_target
// Maps the command fields to two clamped target pulse widths at packet end.
// ----------------------------------------------------------------------------
`default_nettype none

module dslim_target
  import dslim_pkg::*;
#(
  parameter int WIDTH_BITS = WIDTH_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  arm,
  input  wire cmd_fields_t           fields_next,
  input  wire logic [WIDTH_BITS-1:0] width_min,
  input  wire logic [WIDTH_BITS-1:0] width_max,
  input  wire logic [WIDTH_BITS-1:0] width_center,
  output      logic [WIDTH_BITS-1:0] target0,
  output      logic [WIDTH_BITS-1:0] target1
);

  localparam int SW = WIDTH_BITS + 3;
  localparam int MW = BYTE_W + 4;

  logic                  sel_flag0, sel_flag1;
  logic [BYTE_W-1:0]     sel_power0, sel_power1;
  logic [WIDTH_BITS-1:0] map0, map1;

  // center +/- gain*power, clamped to max then to min
  function automatic logic [WIDTH_BITS-1:0] map_width(
    input logic              neg,
    input logic [BYTE_W-1:0] power,
    input logic              gain10,
    input logic [WIDTH_BITS-1:0] c,
    input logic [WIDTH_BITS-1:0] lo,
    input logic [WIDTH_BITS-1:0] hi
  );
    logic [MW-1:0]  x5, x10, mag;
    logic signed [SW-1:0] v;
    x5  = (MW'(power) << 2) + MW'(power);
    x10 = x5 << 1;
    mag = (neg && gain10) ? x10 : x5;
    if (neg) v = $signed(SW'(c)) - $signed(SW'(mag));
    else     v = $signed(SW'(c)) + $signed(SW'(mag));
    if (v > $signed(SW'(hi))) v = $signed(SW'(hi));
    if (v < $signed(SW'(lo))) v = $signed(SW'(lo));
    return WIDTH_BITS'(v);
  endfunction

  // reverse mode swaps the channels; the up channel then backs off at gain 10
  always_comb begin
    sel_flag0  = fields_next.reverse_flag ? fields_next.left_flag  : fields_next.up_flag;
    sel_power0 = fields_next.reverse_flag ? fields_next.left_power : fields_next.up_power;
    sel_flag1  = fields_next.reverse_flag ? fields_next.up_flag    : fields_next.left_flag;
    sel_power1 = fields_next.reverse_flag ? fields_next.up_power   : fields_next.left_power;
    map0 = map_width(sel_flag0, sel_power0, 1'b0, width_center, width_min, width_max);
    map1 = map_width(sel_flag1, sel_power1, fields_next.reverse_flag,
                     width_center, width_min, width_max);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      target0 <= WIDTH_BITS'(TARGET_RST);
      target1 <= WIDTH_BITS'(TARGET_RST);
    end else if (arm) begin
      target0 <= map0;
      target1 <= map1;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/dslim_ramp.sv =====
// ----------------------------------------------------------------------------
// dslim_ramp
// Steps both applied widths toward their targets and holds the result item.
// ----------------------------------------------------------------------------
`default_nettype none

module dslim_ramp
  import dslim_pkg::*;
#(
  parameter int WIDTH_BITS = WIDTH_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire ramp_ctl_t             ctl,
  input  wire logic [STEP_W-1:0]     ramp_step,
  input  wire logic [WIDTH_BITS-1:0] target0,
  input  wire logic [WIDTH_BITS-1:0] target1,
  input  wire logic                  out_ready,
  output      logic                  armed,
  output      logic                  out_valid,
  output      logic [OUT_W-1:0]      out_width_a,
  output      logic [OUT_W-1:0]      out_width_b,
  output      logic                  out_still
);

  `include "assert_macros.svh"

  localparam int AW = WIDTH_BITS + 1;

  logic [WIDTH_BITS-1:0] applied0, applied1;
  logic [WIDTH_BITS:0]   step0, step1;
  logic                  do_step;

  // returns {more, new applied width}
  function automatic logic [WIDTH_BITS:0] step_ch(
    input logic [WIDTH_BITS-1:0] a,
    input logic [WIDTH_BITS-1:0] t,
    input logic [STEP_W-1:0]     s
  );
    logic [AW-1:0]     up_sum, t_plus;
    logic [WIDTH_BITS:0] r;
    up_sum = AW'(a) + AW'(s);
    t_plus = AW'(t) + AW'(s);
    if (t > a) begin
      if (up_sum >= AW'(t)) r = {1'b0, t};
      else                  r = {1'b1, WIDTH_BITS'(up_sum)};
    end else begin
      // a - s stays above t only when a > t + s
      if (AW'(a) > t_plus) r = {1'b1, a - WIDTH_BITS'(s)};
      else                 r = {1'b0, t};
    end
    return r;
  endfunction

  always_comb begin
    do_step = ctl.tick && armed;
    step0   = step_ch(applied0, target0, ramp_step);
    step1   = step_ch(applied1, target1, ramp_step);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      applied0  <= WIDTH_BITS'(TARGET_RST);
      applied1  <= WIDTH_BITS'(TARGET_RST);
      armed     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (ctl.arm) begin
        armed <= 1'b1;
      end else if (do_step) begin
        applied0 <= step0[WIDTH_BITS-1:0];
        applied1 <= step1[WIDTH_BITS-1:0];
        armed    <= step0[WIDTH_BITS] || step1[WIDTH_BITS];
      end
      if (do_step)        out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_step) begin
      out_width_a <= OUT_W'(step0[WIDTH_BITS-1:0]);
      out_width_b <= OUT_W'(step1[WIDTH_BITS-1:0]);
      out_still   <= step0[WIDTH_BITS] || step1[WIDTH_BITS];
    end
  end

  `ASSERT_IMPL(a_idle_on_target, !armed, applied0 == target0 && applied1 == target1, "disarmed off target")
  `ASSERT_NEXT(a_step_result, do_step, out_valid && out_still == armed, "result flag mismatch")
  `ASSERT_IMPL(a_result_source, $rose(out_valid), $past(do_step), "result without tick")

endmodule

`default_nettype wire

// ===== hw/rtl/dual_esc_command_slew_limiter.sv =====
// ----------------------------------------------------------------------------
// dual_esc_command_slew_limiter
// Parses "gas:" command packets and slews two ESC pulse widths per tick.
// ----------------------------------------------------------------------------
// Items enter on the s_axis side: tuser[0] selects a packet byte (0) or a ramp
// tick (1), tdata carries the byte and tlast marks the final byte of a packet.
// The block takes one item per clock. Each item is held in the input
// register and is then processed: the byte parser, the target mapping
// (center +/- 5x or 10x power, clamped) and the per-channel stepper are
// all short logic ahead of their state registers. A tick while ramping
// produces one result item on m_axis the next cycle; ticks while
// not ramping and packet bytes produce none. Input stalls only when a tick
// that would produce a result finds the output register full and unread.
// Configuration writes on cfg_* are always taken (cfg_ready is high); write
// them only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module dual_esc_command_slew_limiter
  import dslim_pkg::*;
#(
  parameter int PACKET_BYTES = PACKET_BYTES_DEF,
  parameter int WIDTH_BITS   = WIDTH_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  // configuration write channel
  input  wire logic                   cfg_valid,
  output      logic                   cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  // input items
  input  wire logic                   s_axis_tvalid,
  output      logic                   s_axis_tready,
  input  wire logic [BYTE_W-1:0]      s_axis_tdata,   // [7:0] data_byte
  input  wire logic [0:0]             s_axis_tuser,   // [0] op
  input  wire logic                   s_axis_tlast,   // last_byte
  // result items
  output      logic                   m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  output      logic [OUT_TDATA_W-1:0] m_axis_tdata    // [11:0] width_a,
                                                      // [23:12] width_b,
                                                      // [24] still_ramping
);

  `include "assert_macros.svh"

  localparam int PAD_W = OUT_TDATA_W - 2 * OUT_W - 1;

  logic [STEP_W-1:0]     ramp_step;
  logic [WIDTH_BITS-1:0] width_min, width_max, width_center;

  logic              in_valid;
  logic              in_op;
  logic [BYTE_W-1:0] in_data;
  logic              in_last;
  logic              in_done;
  logic              out_free;

  pkt_byte_t             pb;
  ramp_ctl_t             ramp_ctl;
  cmd_fields_t           fields_next;
  logic [WIDTH_BITS-1:0] target0, target1;
  logic                  ramp_armed;
  logic [OUT_W-1:0]      out_width_a, out_width_b;
  logic                  out_still;

  // ---------------- configuration registers ----------------
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ramp_step    <= STEP_W'(RAMP_STEP_RST);
      width_min    <= WIDTH_BITS'(WIDTH_MIN_RST);
      width_max    <= WIDTH_BITS'(WIDTH_MAX_RST);
      width_center <= WIDTH_BITS'(WIDTH_CENTER_RST);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_e'(cfg_index))
        REG_RAMP_STEP:    ramp_step    <= STEP_W'(cfg_data);
        REG_WIDTH_MIN:    width_min    <= WIDTH_BITS'(cfg_data);
        REG_WIDTH_MAX:    width_max    <= WIDTH_BITS'(cfg_data);
        REG_WIDTH_CENTER: width_center <= WIDTH_BITS'(cfg_data);
        default: ;
      endcase
    end
  end

  // ---------------- input register ----------------
  // a tick that will step needs a free output slot
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign in_done       = in_valid && (in_op == OP_BYTE || !ramp_armed || out_free);
  assign s_axis_tready = !in_valid || in_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_op   <= s_axis_tuser[0];
      in_data <= s_axis_tdata;
      in_last <= s_axis_tlast;
    end
  end

  always_comb begin
    pb.fire       = in_done && (in_op == OP_BYTE);
    pb.data       = in_data;
    pb.last       = in_last;
    ramp_ctl.tick = in_done && (in_op == OP_TICK);
    ramp_ctl.arm  = pb.fire && in_last;
  end

  // ---------------- processing ----------------
  dslim_parse #(
    .PACKET_BYTES(PACKET_BYTES)
  ) u_parse (
    .clk         (clk),
    .rst         (rst),
    .pb          (pb),
    .fields_next (fields_next)
  );

  dslim_target #(
    .WIDTH_BITS(WIDTH_BITS)
  ) u_target (
    .clk          (clk),
    .rst          (rst),
    .arm          (ramp_ctl.arm),
    .fields_next  (fields_next),
    .width_min    (width_min),
    .width_max    (width_max),
    .width_center (width_center),
    .target0      (target0),
    .target1      (target1)
  );

  dslim_ramp #(
    .WIDTH_BITS(WIDTH_BITS)
  ) u_ramp (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ramp_ctl),
    .ramp_step   (ramp_step),
    .target0     (target0),
    .target1     (target1),
    .out_ready   (m_axis_tready),
    .armed       (ramp_armed),
    .out_valid   (m_axis_tvalid),
    .out_width_a (out_width_a),
    .out_width_b (out_width_b),
    .out_still   (out_still)
  );

  assign m_axis_tdata = {PAD_W'(0), out_still, out_width_b, out_width_a};

  `ASSERT_IMPL(a_no_overrun, ramp_ctl.tick && ramp_armed, out_free, "result overwritten")
  `ASSERT_IMPL(a_stall_has_item, !s_axis_tready, in_valid, "stall with empty input register")
  `ASSERT_NEXT(a_stall_holds, in_valid && !in_done, in_valid && $stable(in_data) && $stable(in_last), "held item lost")

endmodule

`default_nettype wire
